// ===== design/rfo_pkg.sv =====
// Package for the ring FIFO with overwrite.
// Holds the item structs, the operation and status codes and the default sizes.
// No dependencies.
package rfo_pkg;

	localparam int DATA_W         = 32;
	localparam int CNT_W          = 5;
	localparam int CAP_RESET      = 16;
	localparam int DEPTH_DEF      = 16;
	localparam int WORD_BITS_DEF  = 32;

	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_OVW  = 2'd1,
		OP_POP  = 2'd2,
		OP_PEEK = 2'd3
	} op_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		op_t               op;
		logic [DATA_W-1:0] data_in;
	} cmd_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [DATA_W-1:0] data_out;
		logic [CNT_W-1:0]  occupancy;
	} rsp_t;

	// result info handed from pointer control to the output stage
	typedef struct packed {
		logic             rd;
		logic [1:0]       status;
		logic [CNT_W-1:0] occupancy;
	} meta_t;

endpackage

// ===== design/rfo_ram.sv =====
// Generic single-port RAM with registered read data.
// Standalone, no package dependency.
module rfo_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/rfo_ctrl.sv =====
// Pointer and occupancy control of the ring FIFO: capacity register, head, tail, count.
// Issues the slot RAM access for each item. Depends on rfo_pkg.
module rfo_ctrl import rfo_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CNT_W-1:0]         cfg_wdata,
	input  logic                     acc,
	input  op_t                      op,
	output logic                     ram_en,
	output logic                     ram_we,
	output logic [$clog2(DEPTH)-1:0] ram_addr,
	output meta_t                    meta
);

	localparam int PTR_W   = $clog2(DEPTH);
	localparam int CMP_W   = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;
	localparam int CAP_MAX = (DEPTH > (2 ** CNT_W) - 1) ? (2 ** CNT_W) - 1 : DEPTH;
	localparam int CAP_RST = (CAP_RESET > CAP_MAX) ? CAP_MAX : CAP_RESET;

	logic [CNT_W-1:0] cap_q, cap_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [PTR_W-1:0] head_q, head_d;
	logic [PTR_W-1:0] tail_q, tail_d;
	logic [PTR_W-1:0] tail_adv;
	logic [PTR_W-1:0] head_adv;
	logic             full;
	logic             empty;

	function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] idx,
		input logic [CNT_W-1:0] cap);
		logic [CMP_W-1:0] n;
		n = CMP_W'(idx) + CMP_W'(1);
		return (n >= CMP_W'(cap)) ? '0 : PTR_W'(n);
	endfunction

	assign full     = (cnt_q == cap_q);
	assign empty    = (cnt_q == '0);
	assign tail_adv = adv(tail_q, cap_q);
	assign head_adv = adv(head_q, cap_q);

	always_comb begin
		cap_d          = cap_q;
		cnt_d          = cnt_q;
		head_d         = head_q;
		tail_d         = tail_q;
		ram_en         = 1'b0;
		ram_we         = 1'b0;
		ram_addr       = tail_q;
		meta.rd        = 1'b0;
		meta.status    = ST_OK;
		if (acc) begin
			unique case (op)
				OP_PUSH: begin
					if (full) begin
						meta.status = ST_FULL;
					end else begin
						ram_en = 1'b1;
						ram_we = 1'b1;
						tail_d = tail_adv;
						cnt_d  = cnt_q + CNT_W'(1);
					end
				end
				OP_OVW: begin
					ram_en = 1'b1;
					ram_we = 1'b1;
					tail_d = tail_adv;
					if (full) begin
						head_d = tail_adv;
					end else begin
						cnt_d = cnt_q + CNT_W'(1);
					end
				end
				OP_POP: begin
					if (empty) begin
						meta.status = ST_EMPTY;
					end else begin
						ram_en   = 1'b1;
						ram_addr = head_q;
						meta.rd  = 1'b1;
						head_d   = head_adv;
						cnt_d    = cnt_q - CNT_W'(1);
					end
				end
				OP_PEEK: begin
					if (empty) begin
						meta.status = ST_EMPTY;
					end else begin
						ram_en   = 1'b1;
						ram_addr = head_q;
						meta.rd  = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
		meta.occupancy = cnt_d;
		if (cfg_we) begin
			if (cfg_wdata == '0) begin
				cap_d = CNT_W'(1);
			end else if (cfg_wdata > CNT_W'(CAP_MAX)) begin
				cap_d = CNT_W'(CAP_MAX);
			end else begin
				cap_d = cfg_wdata;
			end
			cnt_d  = '0;
			head_d = '0;
			tail_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CNT_W'(CAP_RST);
			cnt_q  <= '0;
			head_q <= '0;
			tail_q <= '0;
		end else begin
			cap_q  <= cap_d;
			cnt_q  <= cnt_d;
			head_q <= head_d;
			tail_q <= tail_d;
		end
	end

	a_cnt_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= cap_q)
		else $error("count above capacity");

	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(CMP_W'(head_q) < CMP_W'(cap_q)) && (CMP_W'(tail_q) < CMP_W'(cap_q)))
		else $error("pointer outside capacity");

	a_ptr_meet: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 || cnt_q == cap_q) |-> head_q == tail_q)
		else $error("head and tail disagree with count");

	a_full_push_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && op == OP_PUSH && full && !cfg_we) |=> $stable(tail_q) && $stable(cnt_q))
		else $error("refused push changed state");

endmodule

// ===== design/rfo_out.sv =====
// Output stage of the ring FIFO: result register with valid/stall handshake.
// Merges slot RAM read data into the result item. Depends on rfo_pkg.
module rfo_out import rfo_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  meta_t                meta,
	input  logic [WORD_BITS-1:0] rdata,
	output logic                 busy,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp
);

	logic                        valid_q;
	meta_t                       meta_s1;
	logic [WORD_BITS+DATA_W-1:0] rdata_wide;

	assign rdata_wide = {{DATA_W{1'b0}}, rdata};
	assign busy       = valid_q && rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			meta_s1 <= meta;
		end
	end

	assign rsp_valid     = valid_q;
	assign rsp.status    = meta_s1.status;
	assign rsp.occupancy = meta_s1.occupancy;
	assign rsp.data_out  = meta_s1.rd ? rdata_wide[DATA_W-1:0] : '0;

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !busy)
		else $error("item loaded over a held result");

	a_read_has_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && meta_s1.rd) |-> meta_s1.status == ST_OK)
		else $error("read data on a failed item");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && meta_s1.status != ST_OK) |-> rsp.data_out == '0)
		else $error("failed item carries data");

endmodule

// ===== design/ring_fifo_with_overwrite_core.sv =====
// Ring FIFO with overwrite push: top level.
// Depends on rfo_pkg, rfo_ctrl, rfo_ram and rfo_out.
//
// Each cmd item is one operation (push, overwrite push, pop, peek) and yields one rsp item
// with status, head word and occupancy. Items are taken one per cycle while no result is
// held by rsp_stall; the rsp item appears in the result register in the cycle after the
// cmd is accepted. Every operation makes at most one access to the single-port slot RAM,
// whose read is registered. A result held by rsp_stall raises cmd_stall. Writing capacity
// empties the queue and keeps slot contents; write it only while no item is in flight.
module ring_fifo_with_overwrite_core import rfo_pkg::*; #(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  cmd_t             cmd,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp
);

	logic                        acc;
	logic                        ram_en;
	logic                        ram_we;
	logic [$clog2(DEPTH)-1:0]    ram_addr;
	logic [WORD_BITS-1:0]        ram_rdata;
	logic [WORD_BITS+DATA_W-1:0] wdata_wide;
	meta_t                       meta;
	logic                        busy;

	assign cmd_stall  = busy;
	assign acc        = cmd_valid && !busy;
	assign wdata_wide = {{WORD_BITS{1'b0}}, cmd.data_in};

	rfo_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.acc      (acc),
		.op       (cmd.op),
		.ram_en   (ram_en),
		.ram_we   (ram_we),
		.ram_addr (ram_addr),
		.meta     (meta)
	);

	rfo_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(wdata_wide[WORD_BITS-1:0]),
		.rdata(ram_rdata)
	);

	rfo_out #(
		.WORD_BITS(WORD_BITS)
	) u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (acc),
		.meta     (meta),
		.rdata    (ram_rdata),
		.busy     (busy),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule

// ===== bench/ring_fifo_with_overwrite_core_test.sv =====
`timescale 1ns / 1ps
// Testbench for ring_fifo_with_overwrite_core: directed table then random traffic,
// each result checked against its table value or an in-bench ring queue predictor.
// Depends on rfo_pkg and ring_fifo_with_overwrite_core.
module ring_fifo_with_overwrite_core_test;
	import rfo_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int PHASES     = 11;
	localparam int PHASE_LEN  = 50;

	typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;
	typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_t;
	typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

	typedef struct packed {
		row_kind_t        kind;
		logic [CNT_W-1:0] cap;
		cmd_t             c;
		logic             fixed;
		rsp_t             want;
	} dir_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [CNT_W-1:0] cfg_wdata = '0;
	logic             cmd_valid = 1'b0;
	logic             cmd_stall;
	cmd_t             cmd = '0;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	rsp_t             rsp;

	ring_fifo_with_overwrite_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [DATA_W-1:0] slot_mem [DEPTH_DEF];
	logic [3:0]        head_ptr = '0;
	logic [3:0]        tail_ptr = '0;
	logic [CNT_W-1:0]  fill_cnt = '0;
	logic [CNT_W-1:0]  cap_q = CNT_W'(CAP_RESET);

	rsp_t        rsp_due_q[$];
	rsp_t        rsp_want;
	int          mism_count = 0;
	int          burst_left = 0;
	int          idle_cycles = 0;
	int          stall_span = 0;
	stall_mode_t stall_mode = STALL_NONE;
	dir_row_t    dir_rows[$];

	function automatic logic [3:0] ring_next(input logic [3:0] idx);
		return (({1'b0, idx} + 5'd1) >= cap_q) ? 4'd0 : idx + 4'd1;
	endfunction

	function automatic rsp_t ring_step(input cmd_t c);
		rsp_t r;
		r.status = ST_OK;
		r.data_out = '0;
		case (c.op)
			OP_PUSH: begin
				if (fill_cnt >= cap_q) begin
					r.status = ST_FULL;
				end else begin
					slot_mem[tail_ptr] = c.data_in;
					tail_ptr = ring_next(tail_ptr);
					fill_cnt = fill_cnt + 1'b1;
				end
			end
			OP_OVW: begin
				slot_mem[tail_ptr] = c.data_in;
				tail_ptr = ring_next(tail_ptr);
				if (fill_cnt < cap_q) fill_cnt = fill_cnt + 1'b1;
				else head_ptr = tail_ptr;
			end
			OP_POP: begin
				if (fill_cnt == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.data_out = slot_mem[head_ptr];
					head_ptr = ring_next(head_ptr);
					fill_cnt = fill_cnt - 1'b1;
				end
			end
			default: begin
				if (fill_cnt == 0) r.status = ST_EMPTY;
				else r.data_out = slot_mem[head_ptr];
			end
		endcase
		r.occupancy = fill_cnt;
		return r;
	endfunction

	task automatic send_item(input cmd_t c, input logic fixed, input rsp_t want);
		rsp_t pred;
		@(negedge clk);
		if (burst_left == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (cmd_stall);
		pred = ring_step(c);
		rsp_due_q.push_back(fixed ? want : pred);
	endtask

	task automatic drain_results();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (rsp_due_q.size() != 0) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [CNT_W-1:0] v);
		drain_results();
		repeat (2) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		cap_q = (v == 0) ? 5'd1 : (v > DEPTH_DEF) ? CNT_W'(DEPTH_DEF) : v;
		head_ptr = '0;
		tail_ptr = '0;
		fill_cnt = '0;
	endtask

	// receiver stall pattern: stretches of no, light or heavy back-pressure
	always @(negedge clk) begin
		if (stall_span == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 2));
			stall_span <= $urandom_range(16, 80);
		end else begin
			stall_span <= stall_span - 1;
		end
		case (stall_mode)
			STALL_NONE:  rsp_stall <= 1'b0;
			STALL_LIGHT: rsp_stall <= ($urandom_range(0, 2) == 0);
			default:     rsp_stall <= ($urandom_range(0, 2) != 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (rsp_due_q.size() == 0) begin
				$error("unexpected result: status %0d data_out %h occupancy %0d",
					rsp.status, rsp.data_out, rsp.occupancy);
				mism_count++;
			end else begin
				rsp_want = rsp_due_q.pop_front();
				if (rsp.status !== rsp_want.status) begin
					$error("status: expected %0d, got %0d", rsp_want.status, rsp.status);
					mism_count++;
				end
				if (rsp.data_out !== rsp_want.data_out) begin
					$error("data_out: expected %h, got %h", rsp_want.data_out, rsp.data_out);
					mism_count++;
				end
				if (rsp.occupancy !== rsp_want.occupancy) begin
					$error("occupancy: expected %0d, got %0d",
						rsp_want.occupancy, rsp.occupancy);
					mism_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		cmd_t    c;
		op_mix_t mix;
		int      p;
		logic [CNT_W-1:0] phase_caps [PHASES];

		phase_caps = '{5'd16, 5'd1, 5'd0, 5'd2, 5'd3, 5'd31,
			5'd17, 5'd5, 5'd8, 5'd4, 5'd16};

		dir_rows = '{
			'{ROW_ITEM, 5'd0,  '{OP_POP,  32'h0},        1'b1, '{ST_EMPTY, 32'h0, 5'd0}},
			'{ROW_ITEM, 5'd0,  '{OP_PEEK, 32'h0},        1'b1, '{ST_EMPTY, 32'h0, 5'd0}},
			'{ROW_ITEM, 5'd0,  '{OP_PUSH, 32'h0},        1'b1, '{ST_OK,    32'h0, 5'd1}},
			'{ROW_ITEM, 5'd0,  '{OP_PUSH, 32'hFFFFFFFF}, 1'b1, '{ST_OK,    32'h0, 5'd2}},
			'{ROW_ITEM, 5'd0,  '{OP_PEEK, 32'hFFFFFFFF}, 1'b0, '0},
			'{ROW_ITEM, 5'd0,  '{OP_POP,  32'hFFFFFFFF}, 1'b0, '0},
			'{ROW_ITEM, 5'd0,  '{OP_POP,  32'h0},        1'b0, '0},
			'{ROW_ITEM, 5'd0,  '{OP_POP,  32'h0},        1'b1, '{ST_EMPTY, 32'h0, 5'd0}},
			'{ROW_CFG,  5'd0,  '0,                       1'b0, '0},
			'{ROW_ITEM, 5'd0,  '{OP_PUSH, 32'hA5A5A5A5}, 1'b1, '{ST_OK,    32'h0, 5'd1}},
			'{ROW_ITEM, 5'd0,  '{OP_PUSH, 32'h5A5A5A5A}, 1'b1, '{ST_FULL,  32'h0, 5'd1}},
			'{ROW_ITEM, 5'd0,  '{OP_OVW,  32'h12345678}, 1'b0, '0},
			'{ROW_ITEM, 5'd0,  '{OP_PEEK, 32'h0},        1'b0, '0},
			'{ROW_ITEM, 5'd0,  '{OP_POP,  32'h0},        1'b0, '0},
			'{ROW_ITEM, 5'd0,  '{OP_OVW,  32'hDEADBEEF}, 1'b1, '{ST_OK,    32'h0, 5'd1}},
			'{ROW_ITEM, 5'd0,  '{OP_POP,  32'h0},        1'b0, '0},
			'{ROW_CFG,  5'd2,  '0,                       1'b0, '0},
			'{ROW_ITEM, 5'd0,  '{OP_PUSH, 32'h00000001}, 1'b0, '0},
			'{ROW_ITEM, 5'd0,  '{OP_PUSH, 32'h00000002}, 1'b0, '0},
			'{ROW_ITEM, 5'd0,  '{OP_PUSH, 32'h00000003}, 1'b1, '{ST_FULL,  32'h0, 5'd2}},
			'{ROW_ITEM, 5'd0,  '{OP_OVW,  32'h00000004}, 1'b0, '0},
			'{ROW_ITEM, 5'd0,  '{OP_POP,  32'h0},        1'b0, '0},
			'{ROW_ITEM, 5'd0,  '{OP_POP,  32'h0},        1'b0, '0},
			'{ROW_ITEM, 5'd0,  '{OP_POP,  32'h0},        1'b1, '{ST_EMPTY, 32'h0, 5'd0}},
			'{ROW_CFG,  5'd17, '0,                       1'b0, '0},
			'{ROW_ITEM, 5'd0,  '{OP_PUSH, 32'h80000000}, 1'b1, '{ST_OK,    32'h0, 5'd1}},
			'{ROW_ITEM, 5'd0,  '{OP_PEEK, 32'h0},        1'b0, '0}
		};

		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) write_capacity(dir_rows[i].cap);
			else send_item(dir_rows[i].c, dir_rows[i].fixed, dir_rows[i].want);
		end

		mix = MIX_FILL;
		for (int ph = 0; ph < PHASES; ph++) begin
			write_capacity(ph == 7 ? CNT_W'($urandom_range(1, 31)) : phase_caps[ph]);
			for (int n = 0; n < PHASE_LEN; n++) begin
				if (n % 10 == 0) mix = op_mix_t'($urandom_range(0, 2));
				if ($urandom_range(0, 39) == 0) drain_results();
				p = $urandom_range(0, 99);
				case (mix)
					MIX_FILL:  c.op = p < 45 ? OP_PUSH : p < 70 ? OP_OVW : p < 85 ? OP_POP : OP_PEEK;
					MIX_DRAIN: c.op = p < 15 ? OP_PUSH : p < 25 ? OP_OVW : p < 80 ? OP_POP : OP_PEEK;
					default:   c.op = op_t'(p % 4);
				endcase
				c.data_in = $urandom;
				send_item(c, 1'b0, '0);
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (mism_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
